[rtl/core/cpum_pkg.sv]
// ----------------------------------------------------------------------------
// CPU utilization monitor package
// Shared constants and types for the utilization monitor and its channels.
// ----------------------------------------------------------------------------
package cpum_pkg;

	localparam int NUM_CORES = 2;
	localparam int CNT_W     = 32;
	localparam int PCT_W     = 7;
	localparam int QBITS     = 7;
	// Idle sum over all cores, one bit wider per doubling of the core count.
	localparam int SUM_W     = CNT_W + $clog2(NUM_CORES);
	// Dividend is the idle sum times one hundred.
	localparam int DIV_W     = SUM_W + QBITS;
	localparam int STEP_W    = $clog2(QBITS);
	localparam int IDX_W     = $clog2(NUM_CORES + 1);
	localparam int CORE_IW   = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

	localparam logic [PCT_W-1:0] PERCENT_FULL = PCT_W'(100);

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [PCT_W-1:0] pct_t;

endpackage

[rtl/core/cpum_sample_if.sv]
// ----------------------------------------------------------------------------
// Sample channel
// Carries one sample request: the wall counter and the idle counter per core.
// ----------------------------------------------------------------------------
interface cpum_sample_if
	import cpum_pkg::*;
();
	logic valid;
	logic ready;
	cnt_t wall_runtime;
	cnt_t idle_runtime_core0;
	cnt_t idle_runtime_core1;

	modport source (output valid, output wall_runtime, output idle_runtime_core0,
		output idle_runtime_core1, input ready);
	modport sink (input valid, input wall_runtime, input idle_runtime_core0,
		input idle_runtime_core1, output ready);
endinterface

[rtl/core/cpum_result_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Carries one result request: the latest busy percentages and an update flag.
// ----------------------------------------------------------------------------
interface cpum_result_if
	import cpum_pkg::*;
();
	logic valid;
	logic ready;
	pct_t busy_percent_core0;
	pct_t busy_percent_core1;
	pct_t busy_percent_total;
	logic updated;

	modport source (output valid, output busy_percent_core0, output busy_percent_core1,
		output busy_percent_total, output updated, input ready);
	modport sink (input valid, input busy_percent_core0, input busy_percent_core1,
		input busy_percent_total, input updated, output ready);
endinterface

[rtl/core/cpu_utilization_percent_monitor.sv]
// ----------------------------------------------------------------------------
// CPU utilization percent monitor
// Each sample request carries a free-running wall counter and the idle counter
// of every core. The block takes modulo-2^32 deltas against the previous
// sample, clamps each idle delta to the wall delta and reports per-core and
// total busy percentages (100 minus the truncated idle share). Nothing is
// recomputed when the stored wall counter is zero or the wall delta is zero;
// the last percentages are then returned with updated low. Every sample gives
// exactly one result. A recomputing sample passes through a clamp state and a
// sum state, then one restoring divider that retires one quotient bit per
// cycle is shared by the per-core and total divisions, seven steps each plus a
// load and a store, and a last state hands the result to the output register.
// A sample that recomputes nothing goes from the clamp state straight to that
// hand-over state. The sample port is not ready until the result is handed to
// the output register, so the block takes no new sample while one is in
// flight, and a result still waiting in the output register holds the
// block longer.
// ----------------------------------------------------------------------------
module cpu_utilization_percent_monitor
	import cpum_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cpum_sample_if.sink   samples,
	cpum_result_if.source results
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_SUM,
		S_LOAD,
		S_DIV,
		S_STORE,
		S_DONE
	} state_t;

	state_t              state_q;
	cnt_t                prev_wall_q;
	cnt_t                prev_idle_q [NUM_CORES];
	cnt_t                dlt_q [NUM_CORES];
	cnt_t                wd_q;
	logic                go_q;
	logic [SUM_W-1:0]    sum_q;
	logic [IDX_W-1:0]    idx_q;
	logic [DIV_W-1:0]    num_q;
	logic [DIV_W-1:0]    den_q;
	logic [STEP_W-1:0]   step_q;
	logic [QBITS-1:0]    quo_q;
	pct_t                core_busy_q [NUM_CORES];
	pct_t                total_busy_q;
	logic                res_vld_q;
	pct_t                res_core0_q;
	pct_t                res_core1_q;
	pct_t                res_total_q;
	logic                res_upd_q;

	cnt_t                idle_in [NUM_CORES];
	logic                is_total;
	logic [SUM_W-1:0]    div_src;
	logic [SUM_W-1:0]    div_den;
	logic [SUM_W-1:0]    sum_nxt;
	logic                ge;
	pct_t                pct;

	assign idle_in[0] = samples.idle_runtime_core0;
	assign idle_in[1] = samples.idle_runtime_core1;

	assign is_total = (idx_q == IDX_W'(NUM_CORES));
	assign div_src  = is_total ? sum_q : SUM_W'(dlt_q[idx_q[CORE_IW-1:0]]);
	// The total divides by the time available on all cores, a core by the wall delta.
	assign div_den  = is_total ? SUM_W'(wd_q) * SUM_W'(NUM_CORES) : SUM_W'(wd_q);
	assign ge       = (num_q >= den_q);
	assign pct      = PERCENT_FULL - quo_q;

	always_comb begin
		sum_nxt = '0;
		for (int c = 0; c < NUM_CORES; c++) begin
			sum_nxt = sum_nxt + SUM_W'(dlt_q[c]);
		end
	end

	assign samples.ready              = (state_q == S_IDLE);
	assign results.valid              = res_vld_q;
	assign results.busy_percent_core0 = res_core0_q;
	assign results.busy_percent_core1 = res_core1_q;
	assign results.busy_percent_total = res_total_q;
	assign results.updated            = res_upd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prev_wall_q  <= '0;
			for (int c = 0; c < NUM_CORES; c++) begin
				prev_idle_q[c] <= '0;
				core_busy_q[c] <= '0;
				dlt_q[c]       <= '0;
			end
			total_busy_q <= '0;
			wd_q         <= '0;
			go_q         <= 1'b0;
			sum_q        <= '0;
			idx_q        <= '0;
			num_q        <= '0;
			den_q        <= '0;
			step_q       <= '0;
			quo_q        <= '0;
			res_vld_q    <= 1'b0;
			res_core0_q  <= '0;
			res_core1_q  <= '0;
			res_total_q  <= '0;
			res_upd_q    <= 1'b0;
		end else begin
			if (results.ready && (state_q != S_DONE)) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (samples.valid) begin
						wd_q <= samples.wall_runtime - prev_wall_q;
						go_q <= (prev_wall_q != '0) &&
							(samples.wall_runtime != prev_wall_q);
						for (int c = 0; c < NUM_CORES; c++) begin
							dlt_q[c]       <= idle_in[c] - prev_idle_q[c];
							prev_idle_q[c] <= idle_in[c];
						end
						prev_wall_q <= samples.wall_runtime;
						state_q     <= S_PREP;
					end
				end
				S_PREP: begin
					if (go_q) begin
						for (int c = 0; c < NUM_CORES; c++) begin
							if (dlt_q[c] > wd_q) begin
								dlt_q[c] <= wd_q;
							end
						end
						state_q <= S_SUM;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SUM: begin
					// Clamped deltas never exceed the wall delta, so the sum stays
					// within the available time of all cores.
					sum_q   <= sum_nxt;
					idx_q   <= '0;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					num_q   <= DIV_W'(div_src) * DIV_W'(PERCENT_FULL);
					den_q   <= DIV_W'(div_den) << (QBITS - 1);
					step_q  <= STEP_W'(QBITS - 1);
					quo_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (ge) begin
						num_q <= num_q - den_q;
					end
					quo_q  <= {quo_q[QBITS-2:0], ge};
					den_q  <= den_q >> 1;
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					if (is_total) begin
						total_busy_q <= pct;
						state_q      <= S_DONE;
					end else begin
						core_busy_q[idx_q[CORE_IW-1:0]] <= pct;
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_LOAD;
					end
				end
				S_DONE: begin
					if (!res_vld_q || results.ready) begin
						res_vld_q   <= 1'b1;
						res_core0_q <= core_busy_q[0];
						res_core1_q <= core_busy_q[1];
						res_total_q <= total_busy_q;
						res_upd_q   <= go_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/cpum_checker.sv]
// ----------------------------------------------------------------------------
// CPU utilization monitor checker
// Port-level checks of the monitor, attached to the top level by bind.
// ----------------------------------------------------------------------------
module cpum_checker
	import cpum_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_valid,
	input logic s_ready,
	input logic r_valid,
	input logic r_ready,
	input pct_t r_core0,
	input pct_t r_core1,
	input pct_t r_total,
	input logic r_updated
);

	// Percentages never exceed one hundred.
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> (r_core0 <= PERCENT_FULL) && (r_core1 <= PERCENT_FULL) &&
			(r_total <= PERCENT_FULL))
		else $error("busy percentage above one hundred");

	// An accepted request moves the block out of idle, so the port drops ready.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !s_ready)
		else $error("sample port ready right after a request");

	// No result can appear in the cycle after a request is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !$rose(r_valid))
		else $error("result appeared one cycle after a request");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_core0) && $stable(r_core1) &&
			$stable(r_total) && $stable(r_updated))
		else $error("stalled result changed");

endmodule

bind cpu_utilization_percent_monitor cpum_checker u_cpum_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_valid   (samples.valid),
	.s_ready   (samples.ready),
	.r_valid   (results.valid),
	.r_ready   (results.ready),
	.r_core0   (results.busy_percent_core0),
	.r_core1   (results.busy_percent_core1),
	.r_total   (results.busy_percent_total),
	.r_updated (results.updated)
);

[sim/cpu_utilization_percent_monitor_tb.sv]
// ----------------------------------------------------------------------------
// CPU utilization percent monitor testbench
// Sends sample requests (wall counter and per-core idle counters) and checks
// every result request field by field against a directed row or an in-bench
// busy percentage predictor. A short directed table covers reset, held
// values, clamping, counter wrap and the extremes; random well-formed counter
// sequences mixed with noise follow. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module cpu_utilization_percent_monitor_tb
	import cpum_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_SAMPLES = 2000;
	localparam int DIRECTED_ROWS  = 16;
	localparam int MAX_GAP        = 13;
	localparam int DRAIN_CYCLES   = 40;
	localparam int STALL_LIMIT    = 2000;

	typedef struct packed {
		cnt_t wall;
		cnt_t idle0;
		cnt_t idle1;
	} sample_t;

	typedef struct packed {
		pct_t core0;
		pct_t core1;
		pct_t total;
		logic updated;
	} busy_t;

	typedef struct packed {
		sample_t smp;
		logic    known;
		busy_t   exp;
	} row_t;

	logic clk;
	logic arst_n;

	cpum_sample_if smp_ch ();
	cpum_result_if res_ch ();

	cpu_utilization_percent_monitor uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp_ch),
		.results (res_ch)
	);

	// Predictor state, mirrors what the block keeps between samples.
	cnt_t last_wall;
	cnt_t last_idle [NUM_CORES];
	pct_t held_core [NUM_CORES];
	pct_t held_total;

	row_t  row_pending [$];
	busy_t busy_expect_q [$];
	int    mismatches;
	int    stall_cycles;
	bit    calm_tx;
	bit    calm_rx;

	// Stimulus-side counters for the random sequences.
	cnt_t wall_ctr;
	cnt_t idle_ctr [NUM_CORES];

	row_t plan [DIRECTED_ROWS];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic busy_t predict_busy(input sample_t s);
		cnt_t idle_now [NUM_CORES];
		cnt_t span;
		cnt_t d;
		logic [63:0] idle_sum;
		logic [63:0] avail;
		busy_t r;
		idle_now[0] = s.idle0;
		idle_now[1] = s.idle1;
		span = s.wall - last_wall;
		r.updated = 1'b0;
		if (last_wall != '0 && span != '0) begin
			idle_sum = '0;
			for (int c = 0; c < NUM_CORES; c++) begin
				d = idle_now[c] - last_idle[c];
				if (d > span)
					d = span;
				idle_sum += 64'(d);
				held_core[c] = PCT_W'(64'(PERCENT_FULL) -
					(64'(d) * 64'(PERCENT_FULL)) / 64'(span));
			end
			avail = 64'(span) * 64'(NUM_CORES);
			if (idle_sum > avail)
				idle_sum = avail;
			held_total = PCT_W'(64'(PERCENT_FULL) - (idle_sum * 64'(PERCENT_FULL)) / avail);
			r.updated = 1'b1;
		end
		last_wall = s.wall;
		for (int c = 0; c < NUM_CORES; c++)
			last_idle[c] = idle_now[c];
		r.core0 = held_core[0];
		r.core1 = held_core[1];
		r.total = held_total;
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned exp,
		input int unsigned act);
		if (exp != act) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
		end
	endfunction

	// Sample acceptance: advance the predictor, queue what the result must be.
	always @(posedge clk) begin
		row_t  row;
		busy_t pred;
		if (arst_n && smp_ch.valid && smp_ch.ready) begin
			pred = predict_busy({smp_ch.wall_runtime, smp_ch.idle_runtime_core0,
				smp_ch.idle_runtime_core1});
			row = row_pending.pop_front();
			busy_expect_q.push_back(row.known ? row.exp : pred);
		end
	end

	// Result acceptance: compare with the oldest expectation.
	always @(posedge clk) begin
		busy_t exp;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (busy_expect_q.size() == 0) begin
				mismatches++;
				$display("%0t: result request with no sample pending, actual %0d %0d %0d %0d",
					$time, res_ch.busy_percent_core0, res_ch.busy_percent_core1,
					res_ch.busy_percent_total, res_ch.updated);
			end else begin
				exp = busy_expect_q.pop_front();
				check_field("busy_percent_core0", exp.core0, res_ch.busy_percent_core0);
				check_field("busy_percent_core1", exp.core1, res_ch.busy_percent_core1);
				check_field("busy_percent_total", exp.total, res_ch.busy_percent_total);
				check_field("updated", exp.updated, res_ch.updated);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic send_sample(input sample_t s, input logic known, input busy_t exp);
		int gap;
		if ($urandom_range(0, 49) == 0)
			calm_tx = !calm_tx;
		gap = calm_tx ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			smp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		row_pending.push_back({s, known, exp});
		smp_ch.valid              <= 1'b1;
		smp_ch.wall_runtime       <= s.wall;
		smp_ch.idle_runtime_core0 <= s.idle0;
		smp_ch.idle_runtime_core1 <= s.idle1;
		@(posedge clk);
		while (!smp_ch.ready) @(posedge clk);
	endtask

	// Next sample of a random sequence; mostly a plausible counter advance.
	task automatic next_random_sample(output sample_t s);
		int   kind;
		cnt_t span;
		cnt_t inc;
		kind = $urandom_range(0, 19);
		if (kind <= 13) begin
			case ($urandom_range(0, 3))
				0: span = $urandom_range(1, 16);
				1: span = $urandom_range(1, 1000);
				2: span = $urandom_range(1, 1000000);
				default: span = $urandom;
			endcase
			wall_ctr += span;
			for (int c = 0; c < NUM_CORES; c++) begin
				case ($urandom_range(0, 7))
					0: inc = '0;
					1: inc = span;
					2: inc = span + $urandom_range(1, 1000);
					default: inc = $urandom_range(0, span);
				endcase
				idle_ctr[c] += inc;
			end
		end else if (kind <= 15) begin
			// Wall counter stands still.
			for (int c = 0; c < NUM_CORES; c++)
				idle_ctr[c] += $urandom_range(0, 50);
		end else if (kind <= 18) begin
			wall_ctr = $urandom;
			for (int c = 0; c < NUM_CORES; c++)
				idle_ctr[c] = $urandom;
		end else begin
			wall_ctr = '0;
			for (int c = 0; c < NUM_CORES; c++)
				idle_ctr[c] += $urandom_range(0, 100);
		end
		s = {wall_ctr, idle_ctr[0], idle_ctr[1]};
	endtask

	task automatic drive_results();
		int w;
		forever begin
			if ($urandom_range(0, 49) == 0)
				calm_rx = !calm_rx;
			w = calm_rx ? 0 : $urandom_range(0, MAX_GAP);
			if (w > 0) begin
				res_ch.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
		end
	endtask

	initial begin
		sample_t s;
		clk = 1'b0;
		arst_n = 1'b0;
		mismatches = 0;
		calm_tx = 1'b0;
		calm_rx = 1'b0;
		last_wall = '0;
		held_total = '0;
		for (int c = 0; c < NUM_CORES; c++) begin
			last_idle[c] = '0;
			held_core[c] = '0;
		end
		smp_ch.valid              <= 1'b0;
		smp_ch.wall_runtime       <= '0;
		smp_ch.idle_runtime_core0 <= '0;
		smp_ch.idle_runtime_core1 <= '0;
		res_ch.ready              <= 1'b0;

		// Rows with known = 0 are checked against the predictor.
		plan = '{
			'{'{32'd1000, 32'd0, 32'd0}, 1'b1, '{7'd0, 7'd0, 7'd0, 1'b0}},
			'{'{32'd2000, 32'd0, 32'd0}, 1'b1, '{7'd100, 7'd100, 7'd100, 1'b1}},
			'{'{32'd2000, 32'd300, 32'd300}, 1'b1, '{7'd100, 7'd100, 7'd100, 1'b0}},
			'{'{32'd3000, 32'd1300, 32'd1300}, 1'b1, '{7'd0, 7'd0, 7'd0, 1'b1}},
			'{'{32'd4000, 32'd9999, 32'd1800}, 1'b0, '0},
			'{'{32'd4003, 32'd10000, 32'd1802}, 1'b0, '0},
			'{'{32'd0, 32'hFFFF_FFFF, 32'd1802}, 1'b0, '0},
			'{'{32'd5000, 32'd0, 32'd0}, 1'b0, '0},
			'{'{32'hFFFF_FFF0, 32'hFFFF_FFF8, 32'd0}, 1'b0, '0},
			'{'{32'h0000_0010, 32'h0000_0008, 32'h0000_0020}, 1'b0, '0},
			'{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
			'{'{32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFF}, 1'b1, '{7'd0, 7'd100, 7'd50, 1'b1}},
			'{'{32'hFFFF_FFFF, 32'hFFFF_FFFD, 32'h0000_0000}, 1'b1, '{7'd0, 7'd0, 7'd0, 1'b1}},
			'{'{32'h8000_0000, 32'h8000_0000, 32'h0000_0000}, 1'b1, '{7'd0, 7'd100, 7'd50, 1'b1}},
			'{'{32'h8000_0000, 32'h8000_0000, 32'h0000_0000}, 1'b1, '{7'd0, 7'd100, 7'd50, 1'b0}},
			'{'{32'h8000_0064, 32'h8000_0001, 32'h0000_0063}, 1'b1, '{7'd99, 7'd1, 7'd50, 1'b1}}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		fork
			drive_results();
		join_none

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_sample(plan[i].smp, plan[i].known, plan[i].exp);

		wall_ctr = $urandom;
		idle_ctr[0] = $urandom;
		idle_ctr[1] = $urandom;
		for (int i = 0; i < RANDOM_SAMPLES; i++) begin
			next_random_sample(s);
			send_sample(s, 1'b0, '0);
		end
		smp_ch.valid <= 1'b0;

		wait (busy_expect_q.size() == 0 && row_pending.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/core/cpum_pkg.sv
rtl/core/cpum_sample_if.sv
rtl/core/cpum_result_if.sv
rtl/core/cpu_utilization_percent_monitor.sv
rtl/core/cpum_checker.sv
sim/cpu_utilization_percent_monitor_tb.sv
